// ----- src/ir_pulse_distance_decoder_top_assert.svh -----
// Assertion helpers for the decoder modules; only irpd_frame includes them.
`ifndef IR_PULSE_DISTANCE_DECODER_TOP_ASSERT_SVH
`define IR_PULSE_DISTANCE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define IRPD_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define IRPD_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- src/irpd_pkg.sv -----
`default_nettype none
package irpd_pkg;

  localparam int DATA_W             = 8;
  localparam int CNT_W              = 5;
  localparam int CODE_W             = 16;
  localparam int IDX_W              = 3;
  localparam int MAX_FRAME_BITS_DEF = 16;

  // register indexes
  localparam logic [IDX_W-1:0] REG_HEADER_MIN = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEADER_MAX = 3'd1;
  localparam logic [IDX_W-1:0] REG_ONE_MIN    = 3'd2;
  localparam logic [IDX_W-1:0] REG_ONE_MAX    = 3'd3;
  localparam logic [IDX_W-1:0] REG_ZERO_MIN   = 3'd4;
  localparam logic [IDX_W-1:0] REG_ZERO_MAX   = 3'd5;
  localparam logic [IDX_W-1:0] REG_FRAME_BITS = 3'd6;

  // reset values
  localparam logic [DATA_W-1:0] RST_HEADER_MIN = 8'h1C;
  localparam logic [DATA_W-1:0] RST_HEADER_MAX = 8'h1D;
  localparam logic [DATA_W-1:0] RST_ONE_MIN    = 8'h10;
  localparam logic [DATA_W-1:0] RST_ONE_MAX    = 8'h11;
  localparam logic [DATA_W-1:0] RST_ZERO_MIN   = 8'h0A;
  localparam logic [DATA_W-1:0] RST_ZERO_MAX   = 8'h0B;
  localparam logic [CNT_W-1:0]  RST_FRAME_BITS = 5'd11;

  typedef struct packed {
    logic [DATA_W-1:0] header_min;
    logic [DATA_W-1:0] header_max;
    logic [DATA_W-1:0] one_min;
    logic [DATA_W-1:0] one_max;
    logic [DATA_W-1:0] zero_min;
    logic [DATA_W-1:0] zero_max;
    logic [CNT_W-1:0]  frame_bits;
  } cfg_t;

  typedef struct packed {
    logic hdr_hit;
    logic one_hit;
    logic zero_hit;
  } hits_t;

endpackage
`default_nettype wire

// ----- src/irpd_in_if.sv -----
`default_nettype none
interface irpd_in_if;
  import irpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] interval_high;
  modport source (output valid, output interval_high, input ready);
  modport sink (input valid, input interval_high, output ready);
endinterface
`default_nettype wire

// ----- src/irpd_out_if.sv -----
`default_nettype none
interface irpd_out_if;
  import irpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code;
  logic              is_new;
  modport source (output valid, output code, output is_new, input ready);
  modport sink (input valid, input code, input is_new, output ready);
endinterface
`default_nettype wire

// ----- src/irpd_cfg_if.sv -----
`default_nettype none
interface irpd_cfg_if;
  import irpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/irpd_cfg_regs.sv -----
`default_nettype none
module irpd_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst,
  irpd_cfg_if.sink     cfg_ch,
  output irpd_pkg::cfg_t cfg
);
  import irpd_pkg::*;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_min <= RST_HEADER_MIN;
      cfg.header_max <= RST_HEADER_MAX;
      cfg.one_min    <= RST_ONE_MIN;
      cfg.one_max    <= RST_ONE_MAX;
      cfg.zero_min   <= RST_ZERO_MIN;
      cfg.zero_max   <= RST_ZERO_MAX;
      cfg.frame_bits <= RST_FRAME_BITS;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_HEADER_MIN: cfg.header_min <= cfg_ch.data;
        REG_HEADER_MAX: cfg.header_max <= cfg_ch.data;
        REG_ONE_MIN:    cfg.one_min    <= cfg_ch.data;
        REG_ONE_MAX:    cfg.one_max    <= cfg_ch.data;
        REG_ZERO_MIN:   cfg.zero_min   <= cfg_ch.data;
        REG_ZERO_MAX:   cfg.zero_max   <= cfg_ch.data;
        REG_FRAME_BITS: cfg.frame_bits <= cfg_ch.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- src/irpd_classify.sv -----
`default_nettype none
module irpd_classify (
  input  wire irpd_pkg::cfg_t               cfg,
  input  wire logic [irpd_pkg::DATA_W-1:0]  interval_high,
  output irpd_pkg::hits_t                   hits
);
  import irpd_pkg::*;

  // an empty window (min above max) never matches
  always_comb begin
    hits.hdr_hit  = (interval_high >= cfg.header_min) && (interval_high <= cfg.header_max);
    hits.one_hit  = (interval_high >= cfg.one_min) && (interval_high <= cfg.one_max);
    hits.zero_hit = (interval_high >= cfg.zero_min) && (interval_high <= cfg.zero_max);
  end
endmodule
`default_nettype wire

// ----- src/irpd_in_reg.sv -----
`default_nettype none
module irpd_in_reg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  irpd_in_if.sink                            in_ch,
  input  wire logic                          drain,
  output logic                               s1_valid,
  output logic [irpd_pkg::DATA_W-1:0]        s1_interval
);
  import irpd_pkg::*;

  logic take;

  assign in_ch.ready = !s1_valid || drain;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (drain) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_interval <= in_ch.interval_high;
    end
  end
endmodule
`default_nettype wire

// ----- src/irpd_frame.sv -----
`default_nettype none
module irpd_frame #(
  parameter int MAX_FRAME_BITS = irpd_pkg::MAX_FRAME_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire irpd_pkg::cfg_t          cfg,
  input  wire irpd_pkg::hits_t         hits,
  input  wire logic                    s1_valid,
  output logic                         drain,
  irpd_out_if.source                   out_ch
);
  import irpd_pkg::*;
  `include "ir_pulse_distance_decoder_top_assert.svh"

  localparam int LEN_W = CNT_W + 1;

  logic                      armed;
  logic                      header_seen;
  logic [CNT_W-1:0]          bit_count;
  logic [MAX_FRAME_BITS-1:0] shift_bits;
  logic [CODE_W-1:0]         last_code;

  logic                      header_seen_next;
  logic [CNT_W-1:0]          bit_count_next;
  logic [MAX_FRAME_BITS-1:0] shift_bits_next;
  logic [LEN_W-1:0]          eff_len;
  logic [MAX_FRAME_BITS+CODE_W-1:0] code_ext;
  logic [CODE_W-1:0]         new_code;
  logic                      step;
  logic                      done;
  logic                      emit;

  assign drain = !out_ch.valid || out_ch.ready;
  assign step  = s1_valid && drain;

  // frame length clamped to 1..MAX_FRAME_BITS
  always_comb begin
    if (cfg.frame_bits == '0) begin
      eff_len = LEN_W'(1);
    end else if ({1'b0, cfg.frame_bits} > LEN_W'(MAX_FRAME_BITS)) begin
      eff_len = LEN_W'(MAX_FRAME_BITS);
    end else begin
      eff_len = {1'b0, cfg.frame_bits};
    end
  end

  always_comb begin
    header_seen_next = header_seen;
    bit_count_next   = bit_count;
    shift_bits_next  = shift_bits;
    if (hits.hdr_hit) begin
      header_seen_next = 1'b1;
    end else if (header_seen && hits.one_hit) begin
      shift_bits_next = {shift_bits[MAX_FRAME_BITS-2:0], 1'b1};
      bit_count_next  = bit_count + CNT_W'(1);
    end else if (header_seen && hits.zero_hit) begin
      shift_bits_next = {shift_bits[MAX_FRAME_BITS-2:0], 1'b0};
      bit_count_next  = bit_count + CNT_W'(1);
    end else begin
      header_seen_next = 1'b0;
      bit_count_next   = '0;
      shift_bits_next  = '0;
    end
  end

  assign done     = {1'b0, bit_count_next} >= eff_len;
  assign code_ext = {{CODE_W{1'b0}}, shift_bits_next};
  assign new_code = code_ext[CODE_W-1:0];
  assign emit     = step && armed && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      header_seen <= 1'b0;
      bit_count   <= '0;
      shift_bits  <= '0;
      last_code   <= '0;
    end else if (step) begin
      if (!armed) begin
        // first edge only starts timing
        armed <= 1'b1;
      end else if (done) begin
        armed       <= 1'b0;
        header_seen <= 1'b0;
        bit_count   <= '0;
        shift_bits  <= '0;
        last_code   <= new_code;
      end else begin
        header_seen <= header_seen_next;
        bit_count   <= bit_count_next;
        shift_bits  <= shift_bits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (emit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.code   <= new_code;
      out_ch.is_new <= (new_code != last_code);
    end
  end

  `IRPD_ASSERT_NOW(a_idle_clear, clk, rst, !armed, (bit_count == '0) && !header_seen)
  `IRPD_ASSERT_NOW(a_no_bits_wo_hdr, clk, rst, !header_seen, bit_count == '0)
  `IRPD_ASSERT_NEXT(a_emit_disarms, clk, rst, emit, !armed && out_ch.valid)
  `IRPD_ASSERT_NEXT(a_last_code, clk, rst, emit, last_code == out_ch.code)
endmodule
`default_nettype wire

// ----- src/ir_pulse_distance_decoder_top.sv -----
// An accepted edge is held in the input register; a code that it completes is then registered on out_ch.
// Throughput: one edge per cycle; only a held result on out_ch stalls the input.
// Reset (rst, synchronous): disarms, clears header, bit count, shift and last code,
// and loads the default timing windows and frame length.
`default_nettype none
module ir_pulse_distance_decoder_top #(
  parameter int MAX_FRAME_BITS = irpd_pkg::MAX_FRAME_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  irpd_in_if.sink      in_ch,
  irpd_out_if.source   out_ch,
  irpd_cfg_if.sink     cfg_ch
);
  import irpd_pkg::*;

  cfg_t              cfg;
  hits_t             hits;
  logic              s1_valid;
  logic [DATA_W-1:0] s1_interval;
  logic              drain;

  irpd_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  irpd_in_reg u_in (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .drain       (drain),
    .s1_valid    (s1_valid),
    .s1_interval (s1_interval)
  );

  irpd_classify u_cls (
    .cfg           (cfg),
    .interval_high (s1_interval),
    .hits          (hits)
  );

  irpd_frame #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .hits     (hits),
    .s1_valid (s1_valid),
    .drain    (drain),
    .out_ch   (out_ch)
  );
endmodule
`default_nettype wire

// ----- tb/ir_pulse_distance_decoder_top_tb.sv -----
`default_nettype none
import irpd_pkg::*;

// Tracks decoder state and holds the codes the decoder has yet to deliver.
class ir_frame_scoreboard;
  cfg_t                          regs;
  bit                            armed;
  bit                            header_seen;
  logic [CNT_W-1:0]              bit_count;
  logic [MAX_FRAME_BITS_DEF-1:0] shift_bits;
  logic [CODE_W-1:0]             last_code;
  logic [CODE_W-1:0]             expected_codes[$];
  bit                            expected_new[$];
  int                            errors;
  int                            results_seen;

  function new();
    regs.header_min = RST_HEADER_MIN;
    regs.header_max = RST_HEADER_MAX;
    regs.one_min    = RST_ONE_MIN;
    regs.one_max    = RST_ONE_MAX;
    regs.zero_min   = RST_ZERO_MIN;
    regs.zero_max   = RST_ZERO_MAX;
    regs.frame_bits = RST_FRAME_BITS;
    armed        = 1'b0;
    header_seen  = 1'b0;
    bit_count    = '0;
    shift_bits   = '0;
    last_code    = '0;
    errors       = 0;
    results_seen = 0;
  endfunction

  function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
    case (idx)
      REG_HEADER_MIN: regs.header_min = d;
      REG_HEADER_MAX: regs.header_max = d;
      REG_ONE_MIN:    regs.one_min = d;
      REG_ONE_MAX:    regs.one_max = d;
      REG_ZERO_MIN:   regs.zero_min = d;
      REG_ZERO_MAX:   regs.zero_max = d;
      REG_FRAME_BITS: regs.frame_bits = d[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function bit in_win(logic [DATA_W-1:0] v, logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function int frame_len();
    int n;
    n = int'(regs.frame_bits);
    if (n == 0) n = 1;
    if (n > MAX_FRAME_BITS_DEF) n = MAX_FRAME_BITS_DEF;
    return n;
  endfunction

  function void note_edge(logic [DATA_W-1:0] v);
    logic [CODE_W-1:0] code;
    // first edge only starts the timer
    if (!armed) begin
      armed = 1'b1;
      return;
    end
    if (in_win(v, regs.header_min, regs.header_max)) begin
      header_seen = 1'b1;
    end else if (header_seen && in_win(v, regs.one_min, regs.one_max)) begin
      shift_bits = {shift_bits[MAX_FRAME_BITS_DEF-2:0], 1'b1};
      bit_count  = bit_count + CNT_W'(1);
    end else if (header_seen && in_win(v, regs.zero_min, regs.zero_max)) begin
      shift_bits = {shift_bits[MAX_FRAME_BITS_DEF-2:0], 1'b0};
      bit_count  = bit_count + CNT_W'(1);
    end else begin
      header_seen = 1'b0;
      bit_count   = '0;
      shift_bits  = '0;
    end
    if (int'(bit_count) < frame_len()) return;
    code = shift_bits[CODE_W-1:0];
    expected_codes.push_back(code);
    expected_new.push_back(code != last_code);
    last_code   = code;
    armed       = 1'b0;
    header_seen = 1'b0;
    bit_count   = '0;
    shift_bits  = '0;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function void check_code(logic [CODE_W-1:0] code, logic is_new);
    logic [CODE_W-1:0] want_code;
    bit                want_new;
    results_seen++;
    if (expected_codes.size() == 0) begin
      flag($sformatf("code %h is_new %b with nothing expected", code, is_new));
      return;
    end
    want_code = expected_codes.pop_front();
    want_new  = expected_new.pop_front();
    if (code !== want_code)
      flag($sformatf("code expected %h actual %h", want_code, code));
    if (is_new !== want_new)
      flag($sformatf("is_new expected %b actual %b (code %h)", want_new, is_new, want_code));
  endfunction
endclass

module ir_pulse_distance_decoder_top_tb;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int WIN_HDR  = 0;
  localparam int WIN_ONE  = 1;
  localparam int WIN_ZERO = 2;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {
    CFG_DEFAULT,
    CFG_DISJOINT,
    CFG_EXTREME,
    CFG_RANDOM,
    CFG_OVERLAP
  } cfg_kind_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  irpd_in_if  in_ch();
  irpd_out_if out_ch();
  irpd_cfg_if cfg_ch();

  ir_pulse_distance_decoder_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  ir_frame_scoreboard sb = new();

  logic [DATA_W-1:0] win_lo[3];
  logic [DATA_W-1:0] win_hi[3];
  logic [CNT_W-1:0]  cur_fb = RST_FRAME_BITS;
  bit                calm = 1'b0;
  bit                hold_req = 1'b0;
  int                sent_items = 0;
  int                stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) sb.check_code(out_ch.code, out_ch.is_new);
      if (in_ch.valid && in_ch.ready) sb.note_edge(in_ch.interval_high);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result receiver: random stalls, or a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99, 0) >= 12);
      end
    end
  end

  task automatic send_edge(input logic [DATA_W-1:0] v);
    in_ch.valid         <= 1'b1;
    in_ch.interval_high <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
    if (!calm && $urandom_range(99, 0) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // leaves valid high so back-to-back writes need no re-raise
  task automatic send_cfg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic end_cfg();
    cfg_ch.valid <= 1'b0;
  endtask

  // no request in flight; an edge may still be in the pipe without a result
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame_bits(input logic [CNT_W-1:0] fb);
    cur_fb = fb;
    send_cfg(REG_FRAME_BITS, {3'b000, fb});
    end_cfg();
  endtask

  function automatic logic [DATA_W-1:0] pick_in(int w);
    if (win_lo[w] <= win_hi[w]) return DATA_W'($urandom_range(win_hi[w], win_lo[w]));
    return DATA_W'($urandom_range(255, 0));
  endfunction

  task automatic send_frame();
    int len;
    len = int'(cur_fb);
    if (len == 0) len = 1;
    if (len > MAX_FRAME_BITS_DEF) len = MAX_FRAME_BITS_DEF;
    send_edge(DATA_W'($urandom_range(255, 0)));
    send_edge(pick_in(WIN_HDR));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99, 0) < 5) send_edge(pick_in(WIN_HDR));
      send_edge($urandom_range(1, 0) ? pick_in(WIN_ONE) : pick_in(WIN_ZERO));
    end
  endtask

  task automatic send_junk();
    int n;
    n = $urandom_range(6, 1);
    if ($urandom_range(1, 0)) begin
      // truncated frame, then whatever follows
      send_edge(DATA_W'($urandom_range(255, 0)));
      send_edge(pick_in(WIN_HDR));
      repeat ($urandom_range(3, 0)) send_edge(pick_in(WIN_ONE));
    end
    repeat (n) send_edge(DATA_W'($urandom_range(255, 0)));
  endtask

  task automatic run_phase(input int n);
    cfg_kind_e         kind;
    int                a[6];
    int                rot;
    int                x;
    logic [DATA_W-1:0] fb_byte;
    kind = (n < 5) ? cfg_kind_e'(n) : cfg_kind_e'($urandom_range(4, 0));
    wait_idle();
    if ($urandom_range(99, 0) < 20) cur_fb = CNT_W'($urandom_range(31, 0));
    else cur_fb = CNT_W'($urandom_range(6, 1));
    case (kind)
      CFG_DEFAULT: begin
        win_lo[WIN_HDR]  = RST_HEADER_MIN;
        win_hi[WIN_HDR]  = RST_HEADER_MAX;
        win_lo[WIN_ONE]  = RST_ONE_MIN;
        win_hi[WIN_ONE]  = RST_ONE_MAX;
        win_lo[WIN_ZERO] = RST_ZERO_MIN;
        win_hi[WIN_ZERO] = RST_ZERO_MAX;
      end
      CFG_DISJOINT: begin
        a[0] = $urandom_range(60, 0);
        for (int i = 1; i < 6; i++)
          a[i] = a[i-1] + ((i % 2) ? $urandom_range(20, 0) : 1 + $urandom_range(60, 0));
        rot = $urandom_range(2, 0);
        for (int w = 0; w < 3; w++) begin
          win_lo[(w + rot) % 3] = DATA_W'(a[2*w]);
          win_hi[(w + rot) % 3] = DATA_W'(a[2*w+1]);
        end
      end
      CFG_EXTREME: begin
        if ($urandom_range(1, 0)) begin
          win_lo[WIN_HDR]  = 8'hFF;
          win_hi[WIN_HDR]  = 8'hFF;
          win_lo[WIN_ONE]  = 8'h01;
          win_hi[WIN_ONE]  = 8'hFE;
          win_lo[WIN_ZERO] = 8'h00;
          win_hi[WIN_ZERO] = 8'h00;
        end else begin
          win_lo[WIN_HDR]  = 8'h00;
          win_hi[WIN_HDR]  = 8'h00;
          win_lo[WIN_ZERO] = 8'h01;
          win_hi[WIN_ZERO] = 8'hFE;
          win_lo[WIN_ONE]  = 8'hFF;
          win_hi[WIN_ONE]  = 8'hFF;
        end
        case ($urandom_range(4, 0))
          0: cur_fb = 5'd0;
          1: cur_fb = 5'd1;
          2: cur_fb = 5'd16;
          3: cur_fb = 5'd17;
          default: cur_fb = 5'd31;
        endcase
      end
      CFG_RANDOM: begin
        // windows may overlap or be empty
        for (int w = 0; w < 3; w++) begin
          win_lo[w] = DATA_W'($urandom_range(255, 0));
          win_hi[w] = DATA_W'($urandom_range(255, 0));
        end
      end
      default: begin
        x = $urandom_range(230, 0);
        win_lo[WIN_HDR]  = DATA_W'(x);
        win_hi[WIN_HDR]  = DATA_W'(x + 5);
        win_lo[WIN_ONE]  = DATA_W'(x);
        win_hi[WIN_ONE]  = DATA_W'(x + 15);
        win_lo[WIN_ZERO] = DATA_W'(x + 10);
        win_hi[WIN_ZERO] = DATA_W'(x + 25);
      end
    endcase
    fb_byte = DATA_W'($urandom_range(255, 0));
    fb_byte[CNT_W-1:0] = cur_fb;
    send_cfg(REG_HEADER_MIN, win_lo[WIN_HDR]);
    send_cfg(REG_HEADER_MAX, win_hi[WIN_HDR]);
    send_cfg(REG_ONE_MIN, win_lo[WIN_ONE]);
    send_cfg(REG_ONE_MAX, win_hi[WIN_ONE]);
    send_cfg(REG_ZERO_MIN, win_lo[WIN_ZERO]);
    send_cfg(REG_ZERO_MAX, win_hi[WIN_ZERO]);
    send_cfg(REG_FRAME_BITS, fb_byte);
    if ($urandom_range(1, 0)) send_cfg(REG_UNUSED, DATA_W'($urandom_range(255, 0)));
    end_cfg();
    calm = (n == 2) || (n == 6);
    // receiver backs off while frames keep coming, so the decoder fills up
    if (n == 2) hold_req = 1'b1;
    repeat ($urandom_range(10, 4)) begin
      if ($urandom_range(99, 0) < 75) send_frame();
      else send_junk();
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [DATA_W-1:0] two_headers[] = '{8'hFF, 8'd29, 8'd17, 8'd10, 8'd16, 8'd11, 8'd28,
                                         8'd16, 8'd16, 8'd10, 8'd10, 8'd17, 8'd11, 8'd16};
    logic [DATA_W-1:0] clears[] = '{8'd0, 8'd28, 8'd200, 8'd16};
    in_ch.valid          <= 1'b0;
    in_ch.interval_high  <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= '0;
    cfg_ch.data          <= '0;
    win_lo[WIN_HDR]  = RST_HEADER_MIN;
    win_hi[WIN_HDR]  = RST_HEADER_MAX;
    win_lo[WIN_ONE]  = RST_ONE_MIN;
    win_hi[WIN_ONE]  = RST_ONE_MAX;
    win_lo[WIN_ZERO] = RST_ZERO_MIN;
    win_hi[WIN_ZERO] = RST_ZERO_MAX;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default windows: full frame with a repeated header in the middle
    foreach (two_headers[i]) send_edge(two_headers[i]);
    // out-of-window interval, then a one bit with no header
    foreach (clears[i]) send_edge(clears[i]);

    // zero frame length acts as one bit; same code twice is not new
    wait_idle();
    set_frame_bits(5'd0);
    send_edge(8'd28);
    send_edge(8'd17);
    send_edge(8'd5);
    send_edge(8'd28);
    send_edge(8'd17);

    // frame length dropped below the bits already collected
    wait_idle();
    set_frame_bits(5'd16);
    send_edge(8'd0);
    send_edge(8'd28);
    send_edge(8'd17);
    send_edge(8'd17);
    send_edge(8'd10);
    wait_idle();
    set_frame_bits(5'd2);
    send_edge(8'd29);

    for (int n = 0; sent_items < 670; n++) run_phase(n);

    in_ch.valid <= 1'b0;
    while (sb.expected_codes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_codes.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+src
src/irpd_pkg.sv
src/irpd_in_if.sv
src/irpd_out_if.sv
src/irpd_cfg_if.sv
src/irpd_cfg_regs.sv
src/irpd_classify.sv
src/irpd_in_reg.sv
src/irpd_frame.sv
src/ir_pulse_distance_decoder_top.sv
tb/ir_pulse_distance_decoder_top_tb.sv
